FILE: hdl/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// shared constants for the decimal factorial engine
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int DIGITS_DEF   = 256;
  localparam int MAX_DIGITS   = 256;
  localparam int GROUP_DIGITS = 16;
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int PROD_W       = 12;
  localparam int CARRY_W      = 8;
  localparam int QUOT_W       = 9;
  localparam int BCD_W        = 4;
  localparam int GROUP_W      = GROUP_DIGITS * BCD_W;
  localparam int DEC_BASE     = 10;
  localparam int RECIP_10     = 3277;
  localparam int RECIP_SHIFT  = 15;

endpackage

FILE: hdl/decimal_factorial_engine_core.sv
// ----------------------------------------------------------------------------
// decimal_factorial_engine_core
// computes n! in decimal and streams it as packed bcd groups
// ----------------------------------------------------------------------------
// usage: drive n and pulse start while busy is low; that edge is the transfer.
// busy stays high until the whole result has been sent.
// results: valid is high for exactly one cycle per group, with bcd_group,
// last and overflow; groups come most significant first, the top group is
// zero padded, last marks the least significant group.
// if n! needs more digits than min(DIGITS, 256), one result with
// bcd_group = 0, last = 1 and overflow = 1 is sent instead.
// operation: for each multiplier from n down to 2 the digit store is swept
// once through the shared divide-by-ten unit, each stored digit being read,
// multiplied and divided, then each digit added by the final carry is split
// off and the pass is closed; then every group of 16 digits is read and
// shifted through the store's read port. n of 0 or 1 gives a single group.
// one item at a time.
// reset: synchronous, returns to idle with no result pending; the digit
// store needs no clearing. the receiver cannot stall: results must be taken.
// ----------------------------------------------------------------------------
module decimal_factorial_engine_core
  import dfe_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         n,
  output logic               valid,
  output logic [GROUP_W-1:0] bcd_group,
  output logic               last,
  output logic               overflow
);

  localparam int CAP = (DIGITS < MAX_DIGITS) ? DIGITS : MAX_DIGITS;
  localparam int AW  = $clog2(CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_DIV,
    S_EXT,
    S_EDIV,
    S_ORD,
    S_OSH
  } state_t;

  state_t             state;
  logic [7:0]         mult;
  logic [CARRY_W-1:0] carry;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [PROD_W-1:0]  t;
  logic [GROUP_W-1:0] word;
  logic               dvld;

  logic [BCD_W-1:0]   mem [CAP];
  logic [BCD_W-1:0]   rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [BCD_W-1:0]   wr_data;

  logic [QUOT_W-1:0]  quot;
  logic [BCD_W-1:0]   rem;
  logic [CNT_W-1:0]   idx_ext;
  logic [CNT_W-1:0]   top_digit;
  logic [BCD_W-1:0]   odigit;

  dfe_div10 u_div10 (
    .dividend  (t),
    .quotient  (quot),
    .remainder (rem)
  );

  assign busy      = (state != S_IDLE);
  assign idx_ext   = {1'b0, idx};
  assign top_digit = count - CNT_W'(1);
  assign odigit    = dvld ? rd_data : '0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rem;
    unique case (state)
      S_IDLE: begin
        wr_en   = start;
        wr_addr = '0;
        wr_data = BCD_W'(1);
      end
      S_RD:   rd_en = 1'b1;
      S_DIV:  wr_en = 1'b1;
      S_EDIV: begin
        wr_en   = 1'b1;
        wr_addr = count[AW-1:0];
      end
      S_ORD:  rd_en = (idx_ext < count);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mult  <= n;
            count <= CNT_W'(1);
            carry <= '0;
            idx   <= '0;
            word  <= '0;
            if (n < 8'd2) begin
              idx   <= IDX_W'(GROUP_DIGITS - 1);
              state <= S_ORD;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          t     <= PROD_W'(rd_data) * PROD_W'(mult) + PROD_W'(carry);
          state <= S_DIV;
        end
        S_DIV: begin
          carry <= quot[CARRY_W-1:0];
          if (idx_ext + CNT_W'(1) == count) begin
            state <= S_EXT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end
        end
        S_EXT: begin
          priority if (carry == '0) begin
            if (mult == 8'd2) begin
              idx   <= {top_digit[IDX_W-1:4], 4'hF};
              word  <= '0;
              state <= S_ORD;
            end else begin
              mult  <= mult - 8'd1;
              idx   <= '0;
              state <= S_RD;
            end
          end else if (count >= CNT_W'(CAP)) begin
            valid     <= 1'b1;
            bcd_group <= '0;
            last      <= 1'b1;
            overflow  <= 1'b1;
            state     <= S_IDLE;
          end else begin
            t     <= PROD_W'(carry);
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          count <= count + CNT_W'(1);
          carry <= quot[CARRY_W-1:0];
          state <= S_EXT;
        end
        S_ORD: begin
          dvld  <= (idx_ext < count);
          state <= S_OSH;
        end
        S_OSH: begin
          if (idx[3:0] == 4'd0) begin
            valid     <= 1'b1;
            bcd_group <= {word[GROUP_W-BCD_W-1:0], odigit};
            last      <= (idx[IDX_W-1:4] == '0);
            overflow  <= 1'b0;
            word      <= '0;
            if (idx[IDX_W-1:4] == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_ORD;
            end
          end else begin
            word  <= {word[GROUP_W-BCD_W-1:0], odigit};
            idx   <= idx - IDX_W'(1);
            state <= S_ORD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/dfe_div10.sv
// ----------------------------------------------------------------------------
// dfe_div10
// shared divide-by-ten unit, reciprocal multiply with remainder
// ----------------------------------------------------------------------------
module dfe_div10
  import dfe_pkg::*;
(
  input  logic [PROD_W-1:0] dividend,
  output logic [QUOT_W-1:0] quotient,
  output logic [BCD_W-1:0]  remainder
);

  localparam int MUL_W = 2 * PROD_W;

  logic [MUL_W-1:0]  prod;
  logic [PROD_W-1:0] back;
  logic [PROD_W-1:0] diff;

  assign prod      = {{PROD_W{1'b0}}, dividend} * MUL_W'(RECIP_10);
  assign quotient  = prod[RECIP_SHIFT +: QUOT_W];
  assign back      = PROD_W'({3'd0, quotient} * PROD_W'(DEC_BASE));
  assign diff      = dividend - back;
  assign remainder = diff[BCD_W-1:0];

endmodule
